// ===== rtl/hermite_polynomial_evaluator_defines.svh =====
// assertion macros for the hermite polynomial evaluator checker
// no dependencies
`ifndef HERMITE_POLYNOMIAL_EVALUATOR_DEFINES_SVH
`define HERMITE_POLYNOMIAL_EVALUATOR_DEFINES_SVH

// implication checked on every rising clock edge out of reset
`define HPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpe check failed");

// next-cycle implication checked on every rising clock edge out of reset
`define HPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpe check failed");

`endif

// ===== rtl/hpe_pkg.sv =====
// shared types, constants and coefficient function for the hermite evaluator
// no dependencies
package hpe_pkg;

    localparam int unsigned MAX_DEG_DEF   = 8;
    localparam int unsigned FRAC_BITS_DEF = 12;
    localparam int unsigned DEG_W         = 4;
    localparam int unsigned X_W           = 16;
    localparam int unsigned VAL_W         = 64;
    localparam int unsigned COEF_W        = 40;
    localparam int unsigned REG_RESET     = 8;

    typedef logic signed [VAL_W-1:0]  t_val;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [DEG_W-1:0]         t_deg;

    typedef struct packed {
        t_deg degree;
        logic last_degree;
        logic end_of_block;
    } t_tag;

    localparam t_val VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam t_val VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // coefficient d of physicists' hermite polynomial of degree n
    function automatic t_coef hermite_coef(input int unsigned n, input int unsigned d);
        longint c [0:15][0:15];
        for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 16; j++) begin
                c[i][j] = 0;
            end
        end
        c[0][0] = 1;
        c[1][1] = 2;
        for (int i = 2; i < 16; i++) begin
            c[i][0] = -2 * (i - 1) * c[i-2][0];
            for (int j = 1; j <= i; j++) begin
                c[i][j] = 2 * c[i-1][j-1] - 2 * (i - 1) * c[i-2][j];
            end
        end
        return t_coef'(c[n][d]);
    endfunction

endpackage

// ===== rtl/hermite_polynomial_evaluator.sv =====
// Hermite polynomial evaluator, top level. Each accepted abscissa yields
// min(max_degree, MAX_DEG)+1 result transactions (nine at reset), degree 0
// upward, one per cycle while the output is not stalled. The rate is set
// by the degree sequencer, which issues one degree per cycle, unless stalled,
// into a horner pipeline of 2*MAX_DEG stages (two per horner step) plus an
// output register, and takes the next abscissa as it issues the last degree.
// Coefficients are constants derived at elaboration; there is no clearing pass.
// depends on hpe_pkg, hpe_seq, hpe_step
module hermite_polynomial_evaluator #(
    parameter int unsigned MAX_DEG   = hpe_pkg::MAX_DEG_DEF,
    parameter int unsigned FRAC_BITS = hpe_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [hpe_pkg::DEG_W-1:0] i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [hpe_pkg::X_W-1:0] i_x_value,
    input  logic                   i_last_sample,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [hpe_pkg::DEG_W-1:0] o_degree,
    output logic [hpe_pkg::VAL_W-1:0] o_poly_value,
    output logic                   o_saturated,
    output logic                   o_last_degree,
    output logic                   o_end_of_block
);
    import hpe_pkg::*;

    localparam int unsigned NS = 2 * MAX_DEG;

    t_deg r_max_degree;
    logic adv;
    logic s_valid;
    logic signed [X_W-1:0] s_x;
    t_tag s_tag;

    logic                  r_v   [0:NS];
    logic signed [X_W-1:0] r_xp  [0:NS];
    t_tag                  r_tg  [0:NS];
    t_deg                  r_n   [0:NS];
    t_val                  f_in  [0:MAX_DEG];
    logic                  sat_in[0:MAX_DEG];

    logic   r_ov;
    t_tag   r_otag;
    t_val   r_oval;
    logic   r_osat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_degree <= t_deg'(REG_RESET);
        end else if (i_cfg_we) begin
            r_max_degree <= i_cfg_data;
        end
    end

    assign adv = !r_ov || i_ready;

    hpe_seq #(.MAX_DEG(MAX_DEG)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_x_value    (i_x_value),
        .i_last_sample(i_last_sample),
        .i_max_degree (r_max_degree),
        .i_adv        (adv),
        .o_valid      (s_valid),
        .o_x          (s_x),
        .o_tag        (s_tag)
    );

    // stage 0 holds the sequencer output; f starts at the coefficient of power MAX_DEG
    assign r_v[0]  = s_valid;
    assign r_xp[0] = s_x;
    assign r_tg[0] = s_tag;
    assign r_n[0]  = s_tag.degree;

    function automatic t_coef coef_at(input t_deg n, input int unsigned d);
        t_coef c;
        c = '0;
        for (int i = 0; i <= MAX_DEG; i++) begin
            if (n == t_deg'(i)) begin
                c = hermite_coef(i, d);
            end
        end
        return c;
    endfunction

    // pad each run so degree n sees MAX_DEG steps: extra leading steps use zero
    // coefficients, which keep f at zero until its top coefficient enters
    assign f_in[0]   = '0;
    assign sat_in[0] = 1'b0;

    for (genvar k = 0; k < MAX_DEG; k++) begin : g_step
        t_coef c_k;
        // step k adds coefficient of power MAX_DEG-1-k, plus top one on step 0
        always_comb begin
            c_k = coef_at(r_n[2*k], MAX_DEG-1-k);
        end
        t_val f_pre;
        assign f_pre = (k == 0) ? (t_val'(coef_at(r_n[0], MAX_DEG)) <<< FRAC_BITS)
                                : f_in[k];
        hpe_step #(.FRAC_BITS(FRAC_BITS)) u_step (
            .i_clk(i_clk),
            .i_en (adv),
            .i_x  (r_xp[2*k]),
            .i_f  (f_pre),
            .i_sat(sat_in[k]),
            .i_c  (c_k),
            .o_f  (f_in[k+1]),
            .o_sat(sat_in[k+1])
        );
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[2*k+1] <= 1'b0;
                r_v[2*k+2] <= 1'b0;
            end else if (adv) begin
                r_v[2*k+1] <= r_v[2*k];
                r_v[2*k+2] <= r_v[2*k+1];
            end
            if (adv) begin
                r_xp[2*k+1] <= r_xp[2*k];
                r_xp[2*k+2] <= r_xp[2*k+1];
                r_tg[2*k+1] <= r_tg[2*k];
                r_tg[2*k+2] <= r_tg[2*k+1];
                r_n[2*k+1]  <= r_n[2*k];
                r_n[2*k+2]  <= r_n[2*k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_v[NS];
        end
        if (adv) begin
            r_otag <= r_tg[NS];
            r_oval <= f_in[MAX_DEG];
            r_osat <= sat_in[MAX_DEG];
        end
    end

    assign o_valid        = r_ov;
    assign o_degree       = r_otag.degree;
    assign o_poly_value   = r_oval;
    assign o_saturated    = r_osat;
    assign o_last_degree  = r_otag.last_degree;
    assign o_end_of_block = r_otag.end_of_block;

endmodule

// ===== rtl/hpe_seq.sv =====
// run sequencer: holds one abscissa and issues one degree per cycle unless stalled
// depends on hpe_pkg
module hpe_seq #(
    parameter int unsigned MAX_DEG = hpe_pkg::MAX_DEG_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [hpe_pkg::X_W-1:0] i_x_value,
    input  logic                   i_last_sample,
    input  logic [hpe_pkg::DEG_W-1:0] i_max_degree,
    input  logic                   i_adv,
    output logic                   o_valid,
    output logic signed [hpe_pkg::X_W-1:0] o_x,
    output hpe_pkg::t_tag          o_tag
);
    import hpe_pkg::*;

    logic         r_busy, n_busy;
    t_deg         r_deg, n_deg;
    t_deg         r_m, n_m;
    logic [X_W-1:0] r_x, n_x;
    logic         r_last, n_last;
    logic         fin;

    assign fin     = r_busy && i_adv && (r_deg == r_m);
    assign o_ready = !r_busy || fin;
    assign o_valid = r_busy;
    assign o_x     = $signed(r_x);
    assign o_tag   = '{degree: r_deg, last_degree: (r_deg == r_m),
                       end_of_block: (r_deg == r_m) && r_last};

    always_comb begin
        n_busy = r_busy;
        n_deg  = r_deg;
        n_m    = r_m;
        n_x    = r_x;
        n_last = r_last;
        if (r_busy && i_adv) begin
            n_deg = r_deg + 1'b1;
            if (fin) begin
                n_busy = 1'b0;
            end
        end
        if (i_valid && o_ready) begin
            n_busy = 1'b1;
            n_deg  = '0;
            n_x    = i_x_value;
            n_last = i_last_sample;
            n_m    = (i_max_degree > t_deg'(MAX_DEG)) ? t_deg'(MAX_DEG) : i_max_degree;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_deg  <= '0;
        end else begin
            r_busy <= n_busy;
            r_deg  <= n_deg;
        end
        r_m    <= n_m;
        r_x    <= n_x;
        r_last <= n_last;
    end

endmodule

// ===== rtl/hpe_step.sv =====
// one horner step in two stages: signed multiply, then shift, saturate, add
// depends on hpe_pkg
module hpe_step #(
    parameter int unsigned FRAC_BITS = hpe_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [hpe_pkg::X_W-1:0] i_x,
    input  hpe_pkg::t_val          i_f,
    input  logic                   i_sat,
    input  hpe_pkg::t_coef         i_c,
    output hpe_pkg::t_val          o_f,
    output logic                   o_sat
);
    import hpe_pkg::*;

    localparam int unsigned PW = VAL_W + X_W;

    // stage a: 64x16 product split in two 32x16 halves
    logic signed [X_W+32:0]  r_plo;
    logic signed [X_W+32:0]  r_phi;
    logic                    r_sat_a;
    t_coef                   r_c_a;
    logic signed [PW-1:0]    prod;
    logic signed [PW-FRAC_BITS-1:0] q;
    t_val                    t;
    logic                    ovf;
    logic signed [VAL_W:0]   cs;
    logic signed [VAL_W:0]   s;
    logic                    ovf2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo   <= i_x * $signed({1'b0, i_f[31:0]});
            r_phi   <= i_x * $signed({i_f[VAL_W-1], i_f[VAL_W-1:32]});
            r_sat_a <= i_sat;
            r_c_a   <= i_c;
        end
    end

    always_comb begin
        prod = (PW'(r_phi) <<< 32) + PW'(r_plo);
        q    = prod[PW-1:FRAC_BITS];
        ovf  = (q > $signed((PW-FRAC_BITS)'(VAL_MAX)))
            || (q < $signed((PW-FRAC_BITS)'(VAL_MIN)));
        t    = ovf ? (q[PW-FRAC_BITS-1] ? VAL_MIN : VAL_MAX) : t_val'(q);
        cs   = (VAL_W+1)'(r_c_a) <<< FRAC_BITS;
        s    = (VAL_W+1)'(t) + cs;
        ovf2 = s[VAL_W] != s[VAL_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_f   <= ovf2 ? (s[VAL_W] ? VAL_MIN : VAL_MAX) : s[VAL_W-1:0];
            o_sat <= r_sat_a | ovf | ovf2;
        end
    end

endmodule

// ===== rtl/hpe_checker.sv =====
// port-level checker for the hermite evaluator, bound to the top level
// depends on hermite_polynomial_evaluator_defines.svh
`include "hermite_polynomial_evaluator_defines.svh"
module hpe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [3:0] o_degree,
    input logic       o_last_degree,
    input logic       o_end_of_block
);
    `HPE_ASSERT_IMP(a_eob_last, i_clk, i_rst_n, o_valid && o_end_of_block, o_last_degree)
    `HPE_ASSERT_NEXT(a_deg_inc, i_clk, i_rst_n, o_valid && i_ready && !o_last_degree, !o_valid || (o_degree == $past(o_degree) + 4'd1))
    `HPE_ASSERT_NEXT(a_deg_zero, i_clk, i_rst_n, o_valid && i_ready && o_last_degree, !o_valid || (o_degree == 4'd0))
    `HPE_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_degree))
endmodule

bind hermite_polynomial_evaluator hpe_checker u_hpe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_degree      (o_degree),
    .o_last_degree (o_last_degree),
    .o_end_of_block(o_end_of_block)
);

// ===== tb/testbench.sv =====
// self-checking testbench for the hermite polynomial evaluator
// predicts every result transaction in a scoreboard class and checks in order
// depends on hpe_pkg and the hermite_polynomial_evaluator rtl
module testbench;
    import hpe_pkg::*;

    localparam int MDEG  = MAX_DEG_DEF;
    localparam int FRAC  = FRAC_BITS_DEF;
    localparam int LAT   = 2 * MDEG + 4;
    localparam int WDOG  = 4000;

    typedef struct {
        logic [3:0]  degree;
        logic [63:0] poly_value;
        logic        saturated;
        logic        last_degree;
        logic        end_of_block;
    } t_hresult;

    class hermite_scoreboard;
        longint coef [0:MDEG][0:MDEG];
        int     top_degree;
        t_hresult pending[$];
        int     errors;

        function void build_table();
            for (int n = 0; n <= MDEG; n++)
                for (int d = 0; d <= MDEG; d++) coef[n][d] = 0;
            coef[0][0] = 1;
            coef[1][1] = 2;
            for (int n = 2; n <= MDEG; n++) begin
                coef[n][0] = -2 * (n - 1) * coef[n-2][0];
                for (int d = 1; d <= n; d++)
                    coef[n][d] = 2 * coef[n-1][d-1] - 2 * (n - 1) * coef[n-2][d];
            end
            top_degree = REG_RESET;
            errors = 0;
        endfunction

        function longint clip(logic signed [127:0] v, inout logic sat);
            logic signed [127:0] hi;
            logic signed [127:0] lo;
            hi = 128'sh7fffffffffffffff;
            lo = -128'sh8000000000000000;
            if (v > hi) begin sat = 1; return 64'sh7fffffffffffffff; end
            if (v < lo) begin sat = 1; return 64'sh8000000000000000; end
            return longint'(v);
        endfunction

        function void note_input(logic [15:0] x, logic last);
            logic signed [127:0] xw;
            logic signed [127:0] acc;
            logic signed [127:0] prod;
            logic sat;
            int m;
            t_hresult r;
            longint f;
            xw = 128'(signed'(x));
            m = (top_degree > MDEG) ? MDEG : top_degree;
            for (int p = 0; p <= m; p++) begin
                sat = 0;
                f = coef[p][p] <<< FRAC;
                for (int d = p - 1; d >= 0; d--) begin
                    prod = (xw * 128'(f)) >>> FRAC;
                    f = clip(prod, sat);
                    acc = 128'(f) + 128'(coef[p][d] <<< FRAC);
                    f = clip(acc, sat);
                end
                r.degree = 4'(p);
                r.poly_value = f;
                r.saturated = sat;
                r.last_degree = (p == m);
                r.end_of_block = (p == m) && last;
                pending.push_back(r);
            end
        endfunction

        function void check_result(t_hresult got);
            t_hresult e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result degree %0d value %0h", $time,
                         got.degree, got.poly_value);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.degree !== e.degree) begin
                $display("%0t degree expected %0d actual %0d", $time, e.degree, got.degree);
                errors++;
            end
            if (got.poly_value !== e.poly_value) begin
                $display("%0t poly_value deg %0d expected %0h actual %0h", $time,
                         e.degree, e.poly_value, got.poly_value);
                errors++;
            end
            if (got.saturated !== e.saturated) begin
                $display("%0t saturated expected %0b actual %0b", $time,
                         e.saturated, got.saturated);
                errors++;
            end
            if (got.last_degree !== e.last_degree) begin
                $display("%0t last_degree expected %0b actual %0b", $time,
                         e.last_degree, got.last_degree);
                errors++;
            end
            if (got.end_of_block !== e.end_of_block) begin
                $display("%0t end_of_block expected %0b actual %0b", $time,
                         e.end_of_block, got.end_of_block);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [3:0]  i_cfg_data = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [15:0] i_x_value = 0;
    logic        i_last_sample = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [3:0]  o_degree;
    logic [63:0] o_poly_value;
    logic        o_saturated;
    logic        o_last_degree;
    logic        o_end_of_block;

    hermite_scoreboard sb;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold = 0;
    int  quiet_cycles = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    hermite_polynomial_evaluator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_x_value(i_x_value), .i_last_sample(i_last_sample),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_degree(o_degree), .o_poly_value(o_poly_value),
        .o_saturated(o_saturated), .o_last_degree(o_last_degree),
        .o_end_of_block(o_end_of_block)
    );

    // input acceptance and result checking at the rising edge
    always @(posedge i_clk) begin
        t_hresult got;
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_input(i_x_value, i_last_sample);
            if (o_valid && i_ready) begin
                got.degree = o_degree;
                got.poly_value = o_poly_value;
                got.saturated = o_saturated;
                got.last_degree = o_last_degree;
                got.end_of_block = o_end_of_block;
                sb.check_result(got);
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WDOG) begin
            $display("[hermite_polynomial_evaluator] ERROR");
            $finish;
        end
    end

    // receiver ready, randomly stalled
    always @(negedge i_clk) begin
        if (recv_hold) i_ready <= 0;
        else i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // valid stays high after acceptance until the next transaction or drain
    task automatic send_x(logic [15:0] x, logic last);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_x_value <= x;
        i_last_sample <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LAT) @(negedge i_clk);
    endtask

    task automatic set_degree(logic [3:0] d);
        drain();
        i_cfg_we <= 1;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.top_degree = int'(d);
    endtask

    task automatic random_x(int count);
        logic [15:0] x;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0: x = 16'($urandom);
                1: x = 16'($urandom_range(8191) - 4096);
                2: x = $urandom_range(1) ? 16'(16'h7fff - $urandom_range(15))
                                         : 16'(16'h8000 + $urandom_range(15));
                default: x = 16'($urandom_range(255) - 128);
            endcase
            send_x(x, $urandom_range(3) == 0);
        end
    endtask

    initial begin
        logic [15:0] corners [0:9];
        sb = new();
        sb.build_table();
        corners = '{16'h0000, 16'h1000, 16'hf000, 16'h7fff, 16'h8000,
                    16'h0001, 16'hffff, 16'h2000, 16'h5555, 16'haaaa};
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // reset degree, field corners
        for (int i = 0; i < 10; i++) send_x(corners[i], i[0]);
        set_degree(4'd0);
        send_x(16'h7fff, 1);
        send_x(16'h8000, 0);
        set_degree(4'd15);
        send_x(16'h8000, 1);
        send_x(16'h7fff, 0);
        set_degree(4'(MDEG - 1));
        send_x(16'h1234, 1);

        // long receiver stall while the sender keeps offering
        drain();
        fork
            begin
                recv_hold = 1;
                repeat (300) @(negedge i_clk);
                recv_hold = 0;
            end
            random_x(12);
        join

        send_idle_pct = 37;
        recv_idle_pct = 75;
        set_degree(4'd3);
        random_x(60);
        set_degree(4'(MDEG));
        random_x(60);

        send_idle_pct = 75;
        recv_idle_pct = 37;
        set_degree(4'd1);
        random_x(50);
        set_degree(4'd15);
        random_x(50);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_degree(4'($urandom_range(15)));
        random_x(60);
        set_degree(4'd0);
        random_x(40);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[hermite_polynomial_evaluator] OK");
        else
            $display("[hermite_polynomial_evaluator] ERROR");
        $finish;
    end
endmodule
